@@ hdl/sfa_pkg.sv @@
package sfa_pkg;

  // Longest sync word the correlator can hold (8..64).
  localparam int MAX_SYNC_BITS = 64;

  localparam int HIST_W     = MAX_SYNC_BITS;
  localparam int BYTE_W     = 8;
  localparam int LANES      = BYTE_W;           // one lane per bit offset
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int CNT_W      = $clog2(BYTE_W);
  localparam int LEN_W      = 7;
  localparam int HDR_W      = 8;
  localparam int PAY_W      = 16;
  localparam int LEFT_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LANE_IDX_W-1:0] lane_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_WORD   = 3'd0,
    REG_SYNC_LEN    = 3'd1,
    REG_HEADER_LEN  = 3'd2,
    REG_CHECK_LEN   = 3'd3,
    REG_PAYLOAD_LEN = 3'd4
  } cfg_reg_e;

  // Where the next search history comes from after one byte.
  typedef enum logic [1:0] {
    HK_KEEP,    // no bit searched, history unchanged
    HK_BIG,     // full history window of some lane
    HK_SMALL,   // short segment that started after a clear
    HK_ZERO     // cleared and nothing searched since
  } hkind_e;

  typedef struct packed {
    logic                           big_hit;
    hist_t                          big_val;
    logic [LANES-1:0]               small_hit;
    logic [LANES-1:0][BYTE_W-1:0]   small_val;
  } lane_res_t;

  typedef struct packed {
    logic                   in_frame;
    logic [CNT_W-1:0]       cnt;
    logic                   done;
    logic                   enter;
    hkind_e                 hkind;
    lane_idx_t              hpos;
    lane_idx_t              hstart;
  } scan_t;

  typedef struct packed {
    byte_t  data;
    logic   frame_first;
    logic   payload_first;
    logic   frame_last;
  } res_t;

endpackage

@@ hdl/sfa_lane.sv @@
// One bit-offset correlator: history match through this bit, plus short
// matches for segments that start after an in-byte clear.
module sfa_lane (
  input  sfa_pkg::lane_idx_t  lane_idx,
  input  sfa_pkg::hist_t      hist,
  input  sfa_pkg::byte_t      in_byte,
  input  sfa_pkg::hist_t      len_mask,
  input  sfa_pkg::hist_t      sync_m,
  input  logic                sync_hi_zero,
  output sfa_pkg::lane_res_t  res
);
  import sfa_pkg::*;

  logic [HIST_W+BYTE_W-1:0] shifted;
  byte_t                    seg;
  byte_t                    low_mask [LANES];

  always_comb begin
    shifted     = {hist, in_byte} >> (lane_idx_t'(LANES - 1) - lane_idx);
    res.big_val = shifted[HIST_W-1:0] & len_mask;
    res.big_hit = (res.big_val == sync_m);
    seg         = shifted[BYTE_W-1:0];
    for (int j = 0; j < LANES; j++) begin
      if (lane_idx_t'(j) <= lane_idx) begin
        low_mask[j]      = byte_t'(8'hFF) >> (lane_idx_t'(LANES - 1) - lane_idx + lane_idx_t'(j));
        res.small_val[j] = seg & low_mask[j] & len_mask[BYTE_W-1:0];
        res.small_hit[j] = sync_hi_zero && (res.small_val[j] == sync_m[BYTE_W-1:0]);
      end else begin
        low_mask[j]      = '0;
        res.small_val[j] = '0;
        res.small_hit[j] = 1'b0;
      end
    end
  end

endmodule

@@ hdl/sfa_merge.sv @@
// Walks the eight bit positions of one byte in time order and decides
// search/frame transitions from the lane hits.
module sfa_merge (
  input  logic                                             in_frame,
  input  logic [sfa_pkg::CNT_W-1:0]                        cnt,
  input  logic                                             total_zero,
  input  logic                                             last_if_done,
  input  logic [sfa_pkg::LANES-1:0]                        big_hit,
  input  logic [sfa_pkg::LANES-1:0][sfa_pkg::LANES-1:0]    small_hit,
  output sfa_pkg::scan_t                                   scan
);
  import sfa_pkg::*;

  logic                 inf;
  logic [CNT_W:0]       cnt_w;
  logic                 clr;
  logic [LANE_IDX_W:0]  cpos;
  logic                 hit;

  always_comb begin
    inf         = in_frame;
    cnt_w       = {1'b0, cnt};
    clr         = 1'b0;
    cpos        = '0;
    hit         = 1'b0;
    scan.done   = 1'b0;
    scan.enter  = 1'b0;
    scan.hkind  = HK_KEEP;
    scan.hpos   = '0;
    scan.hstart = '0;
    for (int t = 0; t < LANES; t++) begin
      if (!inf) begin
        hit         = clr ? small_hit[t][cpos[LANE_IDX_W-1:0]] : big_hit[t];
        scan.hkind  = clr ? HK_SMALL : HK_BIG;
        scan.hpos   = lane_idx_t'(t);
        scan.hstart = cpos[LANE_IDX_W-1:0];
        if (hit) begin
          cnt_w = '0;
          if (total_zero) begin
            // empty frame: drop history, keep searching
            clr        = 1'b1;
            cpos       = (LANE_IDX_W+1)'(t + 1);
            scan.hkind = HK_ZERO;
          end else begin
            inf        = 1'b1;
            scan.enter = 1'b1;
          end
        end
      end else begin
        cnt_w = cnt_w + 1'b1;
        if (cnt_w == (CNT_W+1)'(BYTE_W)) begin
          scan.done = 1'b1;
          cnt_w     = '0;
          if (last_if_done) begin
            inf        = 1'b0;
            clr        = 1'b1;
            cpos       = (LANE_IDX_W+1)'(t + 1);
            scan.hkind = HK_ZERO;
          end
        end
      end
    end
    scan.in_frame = inf;
    scan.cnt      = cnt_w[CNT_W-1:0];
  end

endmodule

@@ hdl/syncword_frame_aligner_unit.sv @@
// Sync word frame aligner. Takes one packed byte per request (bit 7 first in
// time) and searches the bit stream for the configured sync word at every bit
// offset. After a match, the following bits are regrouped into bytes aligned
// to the sync boundary: header + checksum + payload length bytes, each with
// frame_first / payload_first / frame_last flags; then the search restarts at
// the next bit with an empty history. Throughput is one input byte per clock
// while in_stall is low: eight lane comparators (one per bit offset) and the
// merge scan settle the whole byte combinationally. in_stall rises only when
// a result waits in the output register under out_stall and a second one has
// landed in the skid register. Configuration writes are taken at any cycle
// but must only be issued while the block is idle; changing them mid-frame
// misplaces flags.
module syncword_frame_aligner_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input bytes
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sfa_pkg::byte_t                      in_byte,
  // aligned bytes
  output logic                                out_valid,
  input  logic                                out_stall,
  output sfa_pkg::byte_t                      out_byte,
  output logic                                out_frame_first,
  output logic                                out_payload_first,
  output logic                                out_frame_last
);
  import sfa_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] sync_word_r;
  logic [LEN_W-1:0]      sync_len_r;
  logic [HDR_W-1:0]      hdr_len_r;
  logic [HDR_W-1:0]      check_len_r;
  logic [PAY_W-1:0]      payload_len_r;

  // search / framing state
  hist_t                 history_r, history_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [LEFT_W-1:0]     bytes_left_r, bytes_left_nxt;
  byte_t                 accum_r, accum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // output register + skid
  logic                  out_valid_r, out_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  res_t                  out_r, out_nxt;
  res_t                  skid_r, skid_nxt;

  logic                  accept;
  logic                  take;
  logic [LEN_W-1:0]      eff_len;
  hist_t                 len_mask;
  hist_t                 sync_m;
  logic                  sync_hi_zero;
  logic [LEFT_W-1:0]     total;
  lane_res_t             lane_res [LANES];
  logic [LANES-1:0]              big_hit;
  logic [LANES-1:0][LANES-1:0]   small_hit;
  scan_t                 scan;
  res_t                  res;
  logic                  res_v;

  //--------------------------------------------------------------------------
  // Config write port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r   <= '0;
      sync_len_r    <= LEN_W'(32);
      hdr_len_r     <= '0;
      check_len_r   <= '0;
      payload_len_r <= PAY_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SYNC_WORD:   sync_word_r   <= cfg_data;
        REG_SYNC_LEN:    sync_len_r    <= cfg_data[LEN_W-1:0];
        REG_HEADER_LEN:  hdr_len_r     <= cfg_data[HDR_W-1:0];
        REG_CHECK_LEN:   check_len_r   <= cfg_data[HDR_W-1:0];
        REG_PAYLOAD_LEN: payload_len_r <= cfg_data[PAY_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Effective sync length: zero acts as one, long values saturate.
  always_comb begin
    if (sync_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (sync_len_r > LEN_W'(HIST_W)) begin
      eff_len = LEN_W'(HIST_W);
    end else begin
      eff_len = sync_len_r;
    end
    for (int i = 0; i < HIST_W; i++) begin
      len_mask[i] = (LEN_W'(i) < eff_len);
    end
  end

  assign sync_m       = sync_word_r[HIST_W-1:0] & len_mask;
  // short segments (<= 8 bits after a clear) can only match if no high bits
  assign sync_hi_zero = ((sync_m >> BYTE_W) == '0);
  assign total        = LEFT_W'(hdr_len_r) + LEFT_W'(check_len_r)
                      + LEFT_W'(payload_len_r);

  //--------------------------------------------------------------------------
  // Lanes: one correlator per bit offset of the incoming byte
  //--------------------------------------------------------------------------
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    sfa_lane u_lane (
      .lane_idx     (lane_idx_t'(k)),
      .hist         (history_r),
      .in_byte      (in_byte),
      .len_mask     (len_mask),
      .sync_m       (sync_m),
      .sync_hi_zero (sync_hi_zero),
      .res          (lane_res[k])
    );
    assign big_hit[k]   = lane_res[k].big_hit;
    assign small_hit[k] = lane_res[k].small_hit;
  end

  // Merge: sequence the lane hits through the frame state
  sfa_merge u_merge (
    .in_frame     (in_frame_r),
    .cnt          (cnt_r),
    .total_zero   (total == '0),
    .last_if_done (bytes_left_r <= LEFT_W'(1)),
    .big_hit      (big_hit),
    .small_hit    (small_hit),
    .scan         (scan)
  );

  //--------------------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------------------
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    cnt_nxt        = cnt_r;
    accum_nxt      = accum_r;
    bytes_left_nxt = bytes_left_r;
    history_nxt    = history_r;
    if (accept) begin
      in_frame_nxt = scan.in_frame;
      cnt_nxt      = scan.cnt;
      // in-frame bits at the end of a byte are always its last cnt bits
      accum_nxt    = scan.in_frame
                   ? (in_byte & (byte_t'(8'hFF) >> ((CNT_W+1)'(BYTE_W) - {1'b0, scan.cnt})))
                   : '0;
      if (scan.enter) begin
        bytes_left_nxt = total;
      end else if (scan.done) begin
        bytes_left_nxt = (bytes_left_r == '0) ? '0 : bytes_left_r - LEFT_W'(1);
      end
      case (scan.hkind)
        HK_BIG:   history_nxt = lane_res[scan.hpos].big_val;
        HK_SMALL: history_nxt = hist_t'(lane_res[scan.hpos].small_val[scan.hstart]);
        HK_ZERO:  history_nxt = '0;
        default:  history_nxt = history_r;
      endcase
    end
  end

  // A byte completes only when the frame was open at the start of this
  // request, at the bit that brings the accumulator to eight.
  always_comb begin
    res.data          = byte_t'({accum_r, in_byte} >> cnt_r);
    res.frame_first   = (bytes_left_r == total);
    res.payload_first = (bytes_left_r == LEFT_W'(payload_len_r));
    res.frame_last    = (bytes_left_r <= LEFT_W'(1));
    res_v             = accept && scan.done;
  end

  //--------------------------------------------------------------------------
  // Output register with skid
  //--------------------------------------------------------------------------
  assign take     = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = res_v;
        out_nxt        = res;
      end
    end else if (res_v) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r    <= '0;
      in_frame_r   <= 1'b0;
      bytes_left_r <= '0;
      accum_r      <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      history_r    <= history_nxt;
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      accum_r      <= accum_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_r.data;
  assign out_frame_first   = out_r.frame_first;
  assign out_payload_first = out_r.payload_first;
  assign out_frame_last    = out_r.frame_last;

endmodule

@@ hdl/sfa_checker.sv @@
module sfa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_frame_first,
  input logic       out_payload_first,
  input logic       out_frame_last
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_frame_first) && $stable(out_payload_first) && $stable(out_frame_last))
    else $error("stalled result changed");

  // skid full implies the output register is full
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // skid drains as soon as the output is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("skid did not drain");

  // a fresh result needs a request accepted on the cycle before
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without request");

endmodule

bind syncword_frame_aligner_unit sfa_checker u_sfa_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;

  import sfa_pkg::*;

  // Random traffic runs until this many requests have been sent in total.
  localparam int ITEM_GOAL = 725;
  localparam int MAX_REPORTS = 20;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  byte_t in_byte;
  logic out_valid;
  logic out_stall = 1'b0;
  byte_t out_byte;
  logic out_frame_first;
  logic out_payload_first;
  logic out_frame_last;

  syncword_frame_aligner_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_frame_first   (out_frame_first),
    .out_payload_first (out_payload_first),
    .out_frame_last    (out_frame_last)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the aligner: register file plus search / framing state.
  // Lengths kept as ints so frame totals and compares never wrap.
  // ---------------------------------------------------------------------------
  logic [63:0] m_sync_word;
  int          m_sync_len;
  int          m_hdr_len;
  int          m_chk_len;
  int          m_pay_len;

  logic [63:0] m_hist;
  logic        m_in_frame;
  int          m_left;
  byte_t       m_accum;
  int          m_acc_cnt;

  res_t aligned_expect_q[$];  // expected aligned bytes, oldest first
  bit   raw_bits_q[$];        // bit stream waiting to be packed into requests

  int items_sent;
  int results_checked;
  int frames_opened;
  int err_count;
  int burst_left;
  bit sender_steady;          // set: sender never gaps

  // Sync length as the block applies it: zero acts as one, above max saturates.
  function automatic int eff_sync_len();
    if (m_sync_len == 0) return 1;
    if (m_sync_len > MAX_SYNC_BITS) return MAX_SYNC_BITS;
    return m_sync_len;
  endfunction

  // Walk one accepted request bit by bit, MSB first, and queue any byte that
  // completes. At most one byte can complete per request.
  task automatic predict_aligned_bytes(input byte_t val);
    logic [63:0] mask;
    int n;
    int total;
    res_t r;
    logic b_in;
    n = eff_sync_len();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    total = m_hdr_len + m_chk_len + m_pay_len;
    for (int i = 7; i >= 0; i--) begin
      b_in = val[i];
      if (!m_in_frame) begin
        m_hist = ((m_hist << 1) | {63'd0, b_in}) & mask;
        if (m_hist == (m_sync_word & mask)) begin
          m_accum = '0;
          m_acc_cnt = 0;
          // empty frame: nothing to collect, keep hunting from a clean history
          if (total == 0) begin
            m_hist = '0;
          end else begin
            m_in_frame = 1'b1;
            m_left = total;
          end
        end
      end else begin
        m_accum = {m_accum[6:0], b_in};
        m_acc_cnt++;
        if (m_acc_cnt == 8) begin
          // flags follow the live registers, so a mid-frame write can move them
          r.data = m_accum;
          r.frame_first = (m_left == total);
          r.payload_first = (m_left == m_pay_len);
          if (m_left > 0) m_left--;
          r.frame_last = (m_left == 0);
          if (r.frame_first) frames_opened++;
          aligned_expect_q.push_back(r);
          m_accum = '0;
          m_acc_cnt = 0;
          if (r.frame_last) begin
            m_in_frame = 1'b0;
            m_hist = '0;
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, stall pattern on the result side, checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver switches between stall styles after runs of random length:
  // none, light random, heavy random, and a fixed one-in-three pattern.
  int stall_mode;
  int stall_run;
  int stall_tick;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      stall_run = 0;
      stall_tick = 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(20, 200);
      end else begin
        stall_run--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // Pre-edge values of out_* and out_stall are seen here, so acceptance is
  // judged exactly as the block judges it.
  always @(posedge clk) begin : result_check
    res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (aligned_expect_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_byte));
      end else begin
        exp_r = aligned_expect_q.pop_front();
        results_checked++;
        if (out_byte !== exp_r.data)
          report_mismatch($sformatf("out_byte got %02h exp %02h", out_byte, exp_r.data));
        if (out_frame_first !== exp_r.frame_first)
          report_mismatch($sformatf("frame_first got %b exp %b (byte %02h)",
                                    out_frame_first, exp_r.frame_first, exp_r.data));
        if (out_payload_first !== exp_r.payload_first)
          report_mismatch($sformatf("payload_first got %b exp %b (byte %02h)",
                                    out_payload_first, exp_r.payload_first, exp_r.data));
        if (out_frame_last !== exp_r.frame_last)
          report_mismatch($sformatf("frame_last got %b exp %b (byte %02h)",
                                    out_frame_last, exp_r.frame_last, exp_r.data));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers. All are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // One request. Sender runs in bursts; between bursts it may drop valid for
  // a random gap. Acceptance is read at the falling edge, where in_stall has
  // settled to the value the block samples at the next rising edge.
  task automatic send_byte(input byte_t val);
    int gap;
    logic took;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= val;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    predict_aligned_bytes(val);
    items_sent++;
  endtask

  // Stop sending and wait until every expected byte has come out, then let a
  // last request that completes no byte settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (aligned_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leaves the write enable high so back-to-back writes never drop it;
  // cfg_release ends a batch.
  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SYNC_WORD:   m_sync_word = val;
      REG_SYNC_LEN:    m_sync_len = int'(val[6:0]);
      REG_HEADER_LEN:  m_hdr_len = int'(val[7:0]);
      REG_CHECK_LEN:   m_chk_len = int'(val[7:0]);
      REG_PAYLOAD_LEN: m_pay_len = int'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [63:0] word, input int slen, input int hlen,
                              input int clen, input int plen);
    drain();
    cfg_write(REG_SYNC_WORD, word);
    cfg_write(REG_SYNC_LEN, 64'(slen));
    cfg_write(REG_HEADER_LEN, 64'(hlen));
    cfg_write(REG_CHECK_LEN, 64'(clen));
    cfg_write(REG_PAYLOAD_LEN, 64'(plen));
    cfg_release();
  endtask

  // Bit stream builder: bits go in MSB first and leave as packed requests.
  task automatic push_bits(input logic [63:0] val, input int n);
    for (int i = n - 1; i >= 0; i--) raw_bits_q.push_back(val[i]);
  endtask

  task automatic send_ready_bytes();
    byte_t packed_b;
    while (raw_bits_q.size() >= 8) begin
      for (int i = 7; i >= 0; i--) packed_b[i] = raw_bits_q.pop_front();
      send_byte(packed_b);
    end
  endtask

  // Pad the tail to a byte boundary with zeros and send it.
  task automatic flush_bits();
    while (raw_bits_q.size() % 8 != 0) raw_bits_q.push_back(1'b0);
    send_ready_bytes();
  endtask

  // Noise, then the sync word at an arbitrary bit offset, then the frame's
  // random bytes, capped at 40. A broken frame has one sync bit flipped.
  task automatic send_frame(input bit broken);
    int n;
    int total;
    logic [63:0] sw;
    n = eff_sync_len();
    total = m_hdr_len + m_chk_len + m_pay_len;
    if (total > 40) total = 40;
    push_bits({$urandom, $urandom}, $urandom_range(0, 12));
    sw = m_sync_word;
    if (broken) sw = sw ^ (64'd1 << $urandom_range(0, n - 1));
    push_bits(sw, n);
    for (int j = 0; j < total; j++) push_bits(64'($urandom), 8);
    send_ready_bytes();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 16-bit sync at a 3-bit offset, header + check + 2 payload bytes; data
  // bytes hit all-zero and all-one.
  task automatic test_offset_frame();
    apply_config(64'h0000_0000_0000_ACDD, 16, 1, 1, 2);
    push_bits(64'b101, 3);
    push_bits(64'hACDD, 16);
    push_bits(64'h00FF_5AA5, 32);
    flush_bits();
  endtask

  // Sync length zero acts as a single bit; junk above the length is ignored.
  task automatic test_sync_len_zero();
    apply_config(64'hFFFF_FFFF_FFFF_FFF5, 0, 0, 0, 1);
    send_byte(8'h80);
    send_byte(8'h3F);
    send_byte(8'hC3);
  endtask

  // All lengths zero: matches emit nothing; then one payload byte allowed.
  task automatic test_empty_frame();
    apply_config(64'h3C, 8, 0, 0, 0);
    send_byte(8'h3C);
    send_byte(8'h3C);
    send_byte(8'h00);
    drain();
    cfg_write(REG_PAYLOAD_LEN, 64'd1);
    cfg_release();
    send_byte(8'h3C);
    send_byte(8'h77);
  endtask

  // Lengths rewritten while a frame is open: count runs on, flags shift.
  task automatic test_midframe_config();
    apply_config(64'h5A5A, 16, 2, 1, 3);
    send_byte(8'h5A);
    send_byte(8'h5A);
    send_byte(8'h11);
    send_byte(8'h22);
    drain();
    cfg_write(REG_HEADER_LEN, 64'd0);
    cfg_write(REG_PAYLOAD_LEN, 64'd1);
    cfg_release();
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h66);
  endtask

  // Phases of mostly well-formed frames with random content. The first
  // phases pin the sync length extremes; later ones pick at random.
  task automatic test_random_traffic();
    int start;
    int k;
    int slen;
    logic [63:0] word;
    for (int ph = 0; items_sent < ITEM_GOAL; ph++) begin
      k = $urandom_range(0, 9);
      if (ph == 0) slen = 64;
      else if (ph == 1) slen = $urandom_range(65, 127);
      else if (ph == 2) slen = 1;
      else if (k == 0) slen = 0;
      else if (k == 1) slen = 127;
      else slen = $urandom_range(2, 63);
      word = {$urandom, $urandom};
      if (ph == 0) word = '1;
      else if (k == 2) word = '0;
      apply_config(word, slen, $urandom_range(0, 3), $urandom_range(0, 2),
                   $urandom_range(1, 10));
      sender_steady = ($urandom_range(0, 3) == 0);
      start = items_sent;
      while (items_sent - start < 90 && items_sent < ITEM_GOAL) begin
        k = $urandom_range(0, 9);
        if (k < 7) begin
          send_frame(1'b0);
        end else if (k < 8) begin
          send_frame(1'b1);
        end else begin
          repeat ($urandom_range(1, 8)) push_bits(64'($urandom), 8);
          send_ready_bytes();
        end
        // now and then the sender holds off until the pipe is empty, sometimes
        // rewriting a length register in the middle of the stream (maybe mid-frame)
        if ($urandom_range(0, 7) == 0) begin
          drain();
          k = $urandom_range(0, 5);
          if (k == 0) cfg_write(REG_HEADER_LEN, 64'($urandom_range(0, 3)));
          else if (k == 1) cfg_write(REG_CHECK_LEN, 64'($urandom_range(0, 2)));
          else if (k == 2) cfg_write(REG_PAYLOAD_LEN, 64'($urandom_range(0, 10)));
          if (k <= 2) cfg_release();
        end
      end
      flush_bits();
    end
  endtask

  // Largest lengths: frame opens and never finishes within the run. Last,
  // since nothing after it could reach the search state again.
  task automatic test_long_frame();
    apply_config(64'h47, 8, 255, 255, 65535);
    sender_steady = 1'b0;
    send_byte(8'h47);
    repeat (30) send_byte(byte_t'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SYNC_WORD;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_byte <= '0;
    m_sync_word = '0;
    m_sync_len = 32;
    m_hdr_len = 0;
    m_chk_len = 0;
    m_pay_len = 64;
    m_hist = '0;
    m_in_frame = 1'b0;
    m_left = 0;
    m_accum = '0;
    m_acc_cnt = 0;
    items_sent = 0;
    results_checked = 0;
    frames_opened = 0;
    err_count = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_offset_frame();
    test_sync_len_zero();
    test_empty_frame();
    test_midframe_config();
    test_random_traffic();
    test_long_frame();
    drain();
    repeat (8) @(posedge clk);

    $display("run: %0d input bytes, %0d aligned bytes checked, %0d frames opened",
             items_sent, results_checked, frames_opened);
    $display("sync lengths 0..127, empty frames, mid-frame rewrites, max lengths");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("timeout: %0d bytes sent, %0d still expected", items_sent,
             aligned_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
